@@ rtl/core/tsad_pkg.sv @@
package tsad_pkg;

   // Geometry and field widths
   localparam int GRID_SIDE_DEF = 32;
   localparam int COORD_W       = 5;
   localparam int CHAN_W        = 8;
   localparam int PIX_W         = 3 * CHAN_W;
   localparam int SUM_W         = 20;
   localparam int DIFF_W        = CHAN_W + 2;
   localparam int ORIENT_W      = 3;
   localparam int NUM_ORIENT    = 8;
   localparam int CSR_IDX_W     = 1;

   localparam logic [SUM_W-1:0]    SUM_CAP       = 20'hFFFFF;
   localparam logic [SUM_W-1:0]    MAX_SAD_RESET = 20'd783360;
   localparam logic [ORIENT_W-1:0] ORIENT_FIRST  = 3'd0;
   localparam logic [ORIENT_W-1:0] ORIENT_LAST   = 3'd7;

   // Input item kinds
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_CAND = 1'b1;

   // Configuration register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_SAD    = 1'b0,
      CSR_ALL_ORIENT = 1'b1
   } csr_index_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_SEARCH,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic                ref_write;
      logic                cand_load;
      logic                rd_en;
      logic [ORIENT_W-1:0] rd_orient;
      logic                srch_en;
      logic [ORIENT_W-1:0] srch_idx;
      logic                emit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_cand;
      logic req_inside;
      logic req_last;
      logic out_busy;
   } status_type;

   function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

@@ rtl/core/tsad_ifs.sv @@
interface tsad_req_if;
   import tsad_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic [COORD_W-1:0]   cell_row;
   logic [COORD_W-1:0]   cell_col;
   logic [CHAN_W-1:0]    red;
   logic [CHAN_W-1:0]    green;
   logic [CHAN_W-1:0]    blue;
   logic                 last;

   modport source (output valid, mode, cell_row, cell_col, red, green, blue, last,
                   input ready);
   modport sink   (input valid, mode, cell_row, cell_col, red, green, blue, last,
                   output ready);
endinterface

interface tsad_rsp_if;
   import tsad_pkg::*;

   logic                valid;
   logic                ready;
   logic [SUM_W-1:0]    best_sad;
   logic [ORIENT_W-1:0] best_orientation;
   logic                matched;

   modport source (output valid, best_sad, best_orientation, matched, input ready);
   modport sink   (input valid, best_sad, best_orientation, matched, output ready);
endinterface

@@ rtl/core/thumbprint_sad_eight_orientations.sv @@
// Thumbprint comparator: sum of absolute RGB differences over eight orientations.
// req channel: mode 0 stores a reference cell at (cell_row, cell_col), mode 1 a
//   candidate cell. Store every reference cell before candidates (not enforced).
// rsp channel: one result per candidate transfer with last set: smallest sum,
//   its orientation (ties go to the lowest number) and the threshold flag.
// csr port: index 0 writes max_sad, index 1 writes all_orientations. Write only
//   while no comparison is in flight.
// Sequence: a reference load is written as it is taken. A candidate inside the
//   grid takes the transfer, eight reads through the single read port of the
//   reference RAM (one per orientation) and one more step to finish the last sum.
//   A cell outside the grid is dropped. A last cell adds the minimum search (over
//   identity only, or all orientations when all_orientations is set) and a step
//   to load the output register, which waits while the register is stalled.
// Reset: control, sums and configuration return to their defaults; the
//   reference RAM keeps no reset value and must be reloaded.
// Stall: the result waits in the output register and new transfers are taken;
//   the next result waits until it frees up, and no transfer is taken meanwhile.
module thumbprint_sad_eight_orientations #(
   parameter int GRID_SIDE = tsad_pkg::GRID_SIDE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   tsad_req_if.sink                          req,
   tsad_rsp_if.source                        rsp,
   input  logic                              csr_we,
   input  logic [tsad_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tsad_pkg::SUM_W-1:0]        csr_wdata
);
   import tsad_pkg::*;

   logic [SUM_W-1:0] max_sad_ff;
   logic             all_orient_ff;
   cmd_type          cmd;
   status_type       status;
   logic             req_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_sad_ff    <= MAX_SAD_RESET;
         all_orient_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_SAD:    max_sad_ff    <= csr_wdata;
            CSR_ALL_ORIENT: all_orient_ff <= csr_wdata[0];
            default:        ;
         endcase
      end
   end

   tsad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_ready  (req_ready),
      .all_orient (all_orient_ff),
      .status     (status),
      .cmd        (cmd)
   );

   assign req.ready = req_ready;

   tsad_dp #(
      .GRID_SIDE (GRID_SIDE)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_mode             (req.mode),
      .req_cell_row         (req.cell_row),
      .req_cell_col         (req.cell_col),
      .req_red              (req.red),
      .req_green            (req.green),
      .req_blue             (req.blue),
      .req_last             (req.last),
      .rsp_valid            (rsp.valid),
      .rsp_ready            (rsp.ready),
      .rsp_best_sad         (rsp.best_sad),
      .rsp_best_orientation (rsp.best_orientation),
      .rsp_matched          (rsp.matched),
      .max_sad              (max_sad_ff),
      .cmd                  (cmd),
      .status               (status)
   );

endmodule

@@ rtl/core/tsad_ram.sv @@
module tsad_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/tsad_ctrl.sv @@
module tsad_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 all_orient,
   input  tsad_pkg::status_type status,
   output tsad_pkg::cmd_type    cmd
);
   import tsad_pkg::*;

   state_type           state_ff, state_in;
   logic [ORIENT_W-1:0] cnt_ff, cnt_in;
   logic                last_ff, last_in;
   logic                accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = ORIENT_FIRST;
            if (accept && status.req_cand) begin
               last_in = status.req_last;
               if (status.req_inside) begin
                  state_in = ST_READ;
               end else if (status.req_last) begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_READ: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ORIENT_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cnt_in   = ORIENT_FIRST;
            state_in = last_ff ? ST_SEARCH : ST_IDLE;
         end
         ST_SEARCH: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ORIENT_LAST || !all_orient) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd           = '0;
      cmd.rd_orient = cnt_ff;
      cmd.srch_idx  = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.ref_write = accept && !status.req_cand && status.req_inside;
            cmd.cand_load = accept && status.req_cand;
         end
         ST_READ:   cmd.rd_en   = 1'b1;
         ST_DRAIN:  ;
         ST_SEARCH: cmd.srch_en = 1'b1;
         ST_EMIT:   cmd.emit    = !status.out_busy;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= ORIENT_FIRST;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
      end
   end

endmodule

@@ rtl/core/tsad_dp.sv @@
module tsad_dp #(
   parameter int GRID_SIDE = tsad_pkg::GRID_SIDE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request payload
   input  logic                            req_mode,
   input  logic [tsad_pkg::COORD_W-1:0]    req_cell_row,
   input  logic [tsad_pkg::COORD_W-1:0]    req_cell_col,
   input  logic [tsad_pkg::CHAN_W-1:0]     req_red,
   input  logic [tsad_pkg::CHAN_W-1:0]     req_green,
   input  logic [tsad_pkg::CHAN_W-1:0]     req_blue,
   input  logic                            req_last,
   // result
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [tsad_pkg::SUM_W-1:0]      rsp_best_sad,
   output logic [tsad_pkg::ORIENT_W-1:0]   rsp_best_orientation,
   output logic                            rsp_matched,
   // configuration
   input  logic [tsad_pkg::SUM_W-1:0]      max_sad,
   // control
   input  tsad_pkg::cmd_type               cmd,
   output tsad_pkg::status_type            status
);
   import tsad_pkg::*;

   localparam int CW    = $clog2(GRID_SIDE);
   localparam int DEPTH = GRID_SIDE * GRID_SIDE;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [CW-1:0] MAX_COORD = CW'(GRID_SIDE - 1);

   // Reference address of candidate (r, c) under orientation t
   function automatic logic [AW-1:0] ref_addr(input logic [ORIENT_W-1:0] t,
                                              input logic [CW-1:0]       r,
                                              input logic [CW-1:0]       c);
      logic [CW-1:0] rr;
      logic [CW-1:0] cc;
      logic [AW-1:0] hi;
      logic [AW-1:0] lo;
      rr = t[2] ? (MAX_COORD - r) : r;
      cc = t[1] ? (MAX_COORD - c) : c;
      hi = t[0] ? AW'(cc) : AW'(rr);
      lo = t[0] ? AW'(rr) : AW'(cc);
      ref_addr = AW'(hi * AW'(GRID_SIDE)) + lo;
   endfunction

   logic [CW-1:0]       cand_row_ff, cand_col_ff;
   logic [CHAN_W-1:0]   cand_red_ff, cand_green_ff, cand_blue_ff;
   logic                acc_en_ff;
   logic [ORIENT_W-1:0] acc_t_ff;
   logic [SUM_W-1:0]    sums_ff [NUM_ORIENT];
   logic [SUM_W-1:0]    sums_in [NUM_ORIENT];
   logic [SUM_W-1:0]    best_ff;
   logic [ORIENT_W-1:0] best_t_ff;
   logic                rsp_valid_ff;
   logic [SUM_W-1:0]    rsp_sad_ff;
   logic [ORIENT_W-1:0] rsp_orient_ff;
   logic                rsp_matched_ff;

   logic [AW-1:0]       wr_addr, rd_addr;
   logic [PIX_W-1:0]    ref_pix;
   logic [ORIENT_W-1:0] sum_sel;
   logic [SUM_W-1:0]    sum_rd;
   logic [DIFF_W-1:0]   diff;
   logic [SUM_W:0]      sum_wide;
   logic [SUM_W-1:0]    acc_sum;

   // Request decode
   assign status.req_cand   = (req_mode == MODE_CAND);
   assign status.req_inside = (32'(req_cell_row) < 32'(GRID_SIDE)) &&
                              (32'(req_cell_col) < 32'(GRID_SIDE));
   assign status.req_last   = req_last;
   assign status.out_busy   = rsp_valid_ff && !rsp_ready;

   // Reference store
   assign wr_addr = ref_addr(ORIENT_FIRST, CW'(req_cell_row), CW'(req_cell_col));
   assign rd_addr = ref_addr(cmd.rd_orient, cand_row_ff, cand_col_ff);

   tsad_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (cmd.ref_write),
      .wr_addr (wr_addr),
      .wr_data ({req_red, req_green, req_blue}),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ref_pix)
   );

   // Candidate latch
   always_ff @(posedge clock) begin
      if (cmd.cand_load) begin
         cand_row_ff   <= CW'(req_cell_row);
         cand_col_ff   <= CW'(req_cell_col);
         cand_red_ff   <= req_red;
         cand_green_ff <= req_green;
         cand_blue_ff  <= req_blue;
      end
   end

   // Accumulate stage tracks the read in the cycle after it
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_en_ff <= 1'b0;
      end else begin
         acc_en_ff <= cmd.rd_en;
      end
      acc_t_ff <= cmd.rd_orient;
   end

   // Single read mux on the sums: accumulate or search
   assign sum_sel = acc_en_ff ? acc_t_ff : cmd.srch_idx;
   assign sum_rd  = sums_ff[sum_sel];

   assign diff = DIFF_W'(abs_diff(cand_red_ff,   ref_pix[3*CHAN_W-1:2*CHAN_W]))
               + DIFF_W'(abs_diff(cand_green_ff, ref_pix[2*CHAN_W-1:CHAN_W]))
               + DIFF_W'(abs_diff(cand_blue_ff,  ref_pix[CHAN_W-1:0]));
   assign sum_wide = {1'b0, sum_rd} + (SUM_W+1)'(diff);
   assign acc_sum  = sum_wide[SUM_W] ? SUM_CAP : sum_wide[SUM_W-1:0];

   // Saturating sums, cleared once a result is issued
   always_comb begin
      sums_in = sums_ff;
      if (cmd.emit) begin
         for (int i = 0; i < NUM_ORIENT; i++) begin
            sums_in[i] = '0;
         end
      end else if (acc_en_ff) begin
         sums_in[acc_t_ff] = acc_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ORIENT; i++) begin
            sums_ff[i] <= '0;
         end
      end else begin
         sums_ff <= sums_in;
      end
   end

   // Minimum search, ties keep the earlier orientation
   always_ff @(posedge clock) begin
      if (cmd.srch_en) begin
         if (cmd.srch_idx == ORIENT_FIRST || sum_rd < best_ff) begin
            best_ff   <= sum_rd;
            best_t_ff <= cmd.srch_idx;
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_sad_ff     <= best_ff;
         rsp_orient_ff  <= best_t_ff;
         rsp_matched_ff <= (best_ff <= max_sad);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_best_sad         = rsp_sad_ff;
   assign rsp_best_orientation = rsp_orient_ff;
   assign rsp_matched          = rsp_matched_ff;

endmodule

@@ rtl/core/tsad_checker.sv @@
module tsad_checker #(
   parameter int GRID_SIDE = tsad_pkg::GRID_SIDE_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            req_mode,
   input logic [tsad_pkg::COORD_W-1:0]    req_cell_row,
   input logic [tsad_pkg::COORD_W-1:0]    req_cell_col,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [tsad_pkg::SUM_W-1:0]      rsp_best_sad,
   input logic [tsad_pkg::ORIENT_W-1:0]   rsp_best_orientation,
   input logic                            rsp_matched
);
   import tsad_pkg::*;

   logic req_xfer, cand_inside;

   assign req_xfer    = req_valid && req_ready;
   assign cand_inside = (req_mode == MODE_CAND) &&
                        (32'(req_cell_row) < 32'(GRID_SIDE)) &&
                        (32'(req_cell_col) < 32'(GRID_SIDE));

   // A stalled result stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_best_sad) &&
         $stable(rsp_best_orientation) && $stable(rsp_matched))
      else $error("result payload changed while stalled");

   // A candidate inside the grid occupies the block for the orientation reads
   a_cand_busy: assert property (@(posedge clock) disable iff (reset)
      req_xfer && cand_inside |=> !req_ready)
      else $error("request taken during orientation reads");

   // A reference load never produces a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_mode == MODE_LOAD) && !rsp_valid |=> !rsp_valid)
      else $error("result after a reference load");

endmodule

bind thumbprint_sad_eight_orientations tsad_checker #(
   .GRID_SIDE (GRID_SIDE)
) u_tsad_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req.valid),
   .req_ready            (req.ready),
   .req_mode             (req.mode),
   .req_cell_row         (req.cell_row),
   .req_cell_col         (req.cell_col),
   .rsp_valid            (rsp.valid),
   .rsp_ready            (rsp.ready),
   .rsp_best_sad         (rsp.best_sad),
   .rsp_best_orientation (rsp.best_orientation),
   .rsp_matched          (rsp.matched)
);
